### design/bdq_pkg.sv
// shared types, codes and ring arithmetic for the bounded double-ended queue
// no dependencies; used by every design file through scoped names
package bdq_pkg;

  // queue geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  // field widths
  localparam int REQ_W  = 2;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic take;     // request transfer at this edge
    logic load_rd;  // load result from the memory read register
  } bdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_go;   // current request is a pop on a non-empty queue
  } bdq_stat_t;

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
  function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

### design/bounded_double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words, bdq_pkg::DEPTH entries
// held in a ring with a head pointer and an entry count. Every request
// transfer (push front, push back, pop front, pop back) gives exactly one
// result transfer carrying the popped word (zero for pushes and refused pops),
// a status (ok, full, empty) and the occupancy after the request. Pushes and
// refused requests set result valid in the cycle after the request transfer;
// an accepted pop first passes a read wait state, as the ring memory has a
// registered read port and the popped word is only there in the cycle after
// the address is set. A request is taken only when no pop awaits its word
// and the result register is free or being emptied, so pushes run at one per
// cycle unless results stall. After reset the queue is empty; no clearing
// pass runs; the storage needs none, as only written entries are ever popped.
//
// depends on bdq_pkg, bdq_ctrl, bdq_dp
module bounded_double_ended_queue (
  input  logic          clk,
  input  logic          rst_n,
  // request channel
  input  logic          in_valid,
  output logic          in_ready,
  input  bdq_pkg::req_t in_payload,
  // result channel
  output logic          out_valid,
  input  logic          out_ready,
  output bdq_pkg::rsp_t out_payload
);

  // command and status between controller and datapath
  bdq_pkg::bdq_cmd_t  cmd;
  bdq_pkg::bdq_stat_t stat;

  // handshake and sequencing
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // ring storage, pointers and result register
  bdq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .cmd         (cmd),
    .stat        (stat),
    .out_payload (out_payload)
  );

endmodule

### design/bdq_dp.sv
// datapath: ring storage, head pointer, entry count and result register
// depends on bdq_pkg; driven by bdq_ctrl commands
module bdq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  bdq_pkg::req_t     in_payload,
  input  bdq_pkg::bdq_cmd_t cmd,
  output bdq_pkg::bdq_stat_t stat,
  output bdq_pkg::rsp_t     out_payload
);

  logic [bdq_pkg::WORD_W-1:0] mem [bdq_pkg::DEPTH];

  logic [bdq_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic [bdq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bdq_pkg::WORD_W-1:0] rd_data_r;
  bdq_pkg::rsp_t              out_r, out_nxt;

  logic                       is_push, is_pop, full, empty;
  logic                       wr_en;
  logic [bdq_pkg::IDX_W-1:0]  wr_addr, rd_addr, head_dec, head_inc;
  logic [bdq_pkg::CNT_W-1:0]  back_off;
  logic [bdq_pkg::STAT_W-1:0] status;

  always_comb begin
    is_push  = (in_payload.req_type == bdq_pkg::REQ_PUSH_FRONT) ||
               (in_payload.req_type == bdq_pkg::REQ_PUSH_BACK);
    is_pop   = !is_push;
    full     = (count_r == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    empty    = (count_r == '0);
    head_dec = (head_r == '0) ? bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1)
                              : head_r - 1'b1;
    head_inc = bdq_pkg::ring_add(head_r, bdq_pkg::CNT_W'(1));
    back_off = empty ? '0 : count_r - 1'b1;

    wr_addr = (in_payload.req_type == bdq_pkg::REQ_PUSH_FRONT) ? head_dec
              : bdq_pkg::ring_add(head_r, count_r);
    rd_addr = (in_payload.req_type == bdq_pkg::REQ_POP_FRONT) ? head_r
              : bdq_pkg::ring_add(head_r, back_off);
    wr_en   = cmd.take && is_push && !full;

    stat.pop_go = is_pop && !empty;

    head_nxt  = head_r;
    count_nxt = count_r;
    status    = bdq_pkg::ST_OK;
    if (is_push) begin
      if (full) begin
        status = bdq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
        if (in_payload.req_type == bdq_pkg::REQ_PUSH_FRONT) begin
          head_nxt = head_dec;
        end
      end
    end else begin
      if (empty) begin
        status = bdq_pkg::ST_EMPTY;
      end else begin
        count_nxt = count_r - 1'b1;
        if (in_payload.req_type == bdq_pkg::REQ_POP_FRONT) begin
          head_nxt = head_inc;
        end
      end
    end

    out_nxt = out_r;
    if (cmd.load_rd) begin
      out_nxt.data_out  = rd_data_r;
      out_nxt.status    = bdq_pkg::ST_OK;
      out_nxt.occupancy = bdq_pkg::OCC_W'(count_r);
    end else if (cmd.take) begin
      out_nxt.data_out  = '0;
      out_nxt.status    = status;
      out_nxt.occupancy = bdq_pkg::OCC_W'(count_nxt);
    end
  end

  // ring storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_payload.data_in;
    end
    if (cmd.take) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.take) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_payload = out_r;

endmodule

### design/bdq_ctrl.sv
// controller: request handshake, memory read wait state and result valid
// depends on bdq_pkg; steers bdq_dp
module bdq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bdq_pkg::bdq_stat_t stat,
  output bdq_pkg::bdq_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    cmd.take    = in_valid && in_ready;
    cmd.load_rd = (state_r == S_RD);

    state_nxt = S_IDLE;
    if (cmd.take && stat.pop_go) begin
      state_nxt = S_RD;
    end

    out_valid_nxt = out_valid_r;
    if ((cmd.take && !stat.pop_go) || cmd.load_rd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### design/bdq_checker.sv
// port-level checks for the bounded double-ended queue
// depends on bdq_pkg; bound to bounded_double_ended_queue
module bdq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input bdq_pkg::req_t in_payload,
  input logic          out_valid,
  input logic          out_ready,
  input bdq_pkg::rsp_t out_payload
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // refused requests carry a zero word
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_payload.status != bdq_pkg::ST_OK) |-> out_payload.data_out == '0)
    else $error("refused request returned a nonzero word");

  // refusal status agrees with occupancy
  a_status_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_payload.status == bdq_pkg::ST_EMPTY &&
                   out_payload.occupancy != '0) ||
                  (out_payload.status == bdq_pkg::ST_FULL &&
                   out_payload.occupancy != bdq_pkg::OCC_W'(bdq_pkg::DEPTH))) |-> 1'b0)
    else $error("refusal status disagrees with occupancy");

  // a push transfer answers in the next cycle
  a_push_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_payload.req_type == bdq_pkg::REQ_PUSH_FRONT ||
     in_payload.req_type == bdq_pkg::REQ_PUSH_BACK) |=> out_valid)
    else $error("push result not valid in the next cycle");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (.*);

### tb/sv/bounded_double_ended_queue_tb.sv
`timescale 1ns / 1ps
// self-checking regression for the bounded double-ended queue: directed vectors, then random runs
// depends on bdq_pkg and bounded_double_ended_queue; keeps its own ring model for prediction
module bounded_double_ended_queue_tb;
  import bdq_pkg::*;

  localparam int RANDOM_PER_PHASE = 175;   // four phases, about 700 random requests
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 8;     // pops pass through a read wait state, leave a little margin

  // shape of a burst of random requests
  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} burst_mode_t;

  // one row of stimulus; fixed rows carry a hand-written expected result
  typedef struct {
    req_t req;
    bit   fixed;
    rsp_t rsp;
  } request_vector_t;

  localparam rsp_t NO_RSP = '0;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // dut inputs start at known values
  logic  in_valid   = 1'b0;
  req_t  in_payload = '0;
  logic  out_ready  = 1'b0;
  logic  in_ready;
  logic  out_valid;
  rsp_t  out_payload;

  // travels with the request so the monitor sees it at the transfer edge
  logic  vec_fixed = 1'b0;
  rsp_t  vec_rsp   = '0;

  // idling percentages for the current phase
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // ring model of the queue
  logic signed [WORD_W-1:0] ring_words [DEPTH];
  int unsigned              ring_head  = 0;
  int unsigned              ring_count = 0;

  rsp_t expected_responses [$];
  request_vector_t directed_table [$];

  int unsigned requests_issued = 0;
  int unsigned requests_taken  = 0;
  int unsigned results_seen    = 0;
  int unsigned full_refusals   = 0;
  int unsigned empty_refusals  = 0;
  int unsigned words_popped    = 0;
  int unsigned errors          = 0;
  int unsigned cycle_count     = 0;

  bounded_double_ended_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_responses.size());
      $display("bounded_double_ended_queue regression: fail");
      $finish;
    end
  end

  // receiver stalls at random, rate set per phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // advance the ring model by one request and return the result it gives
  function automatic rsp_t predict_response(req_t r);
    rsp_t        rsp;
    int unsigned pos;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          // full: refused, nothing moves
          rsp.status = ST_FULL;
        end else if (r.req_type == REQ_PUSH_FRONT) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_words[ring_head] = r.data_in;
          ring_count++;
        end else begin
          pos = (ring_head + ring_count) % DEPTH;
          ring_words[pos] = r.data_in;
          ring_count++;
        end
      end
      default: begin
        if (ring_count == 0) begin
          // empty: refused, word reads as zero
          rsp.status = ST_EMPTY;
        end else if (r.req_type == REQ_POP_FRONT) begin
          rsp.data_out = ring_words[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
        end else begin
          pos = (ring_head + ring_count - 1) % DEPTH;
          rsp.data_out = ring_words[pos];
          ring_count--;
        end
      end
    endcase
    rsp.occupancy = OCC_W'(ring_count);
    return rsp;
  endfunction

  // monitor: predict on request transfer, check on result transfer
  rsp_t predicted;
  rsp_t oldest;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        // model always advances, even when the row has its own expectation
        predicted = predict_response(in_payload);
        expected_responses.push_back(vec_fixed ? vec_rsp : predicted);
        requests_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_responses.size() == 0) begin
          $error("result transfer with nothing outstanding: %p", out_payload);
          errors++;
        end else begin
          oldest = expected_responses.pop_front();
          if (out_payload.data_out !== oldest.data_out) begin
            $error("data_out: expected %0d (%h), actual %0d (%h)", oldest.data_out,
                   oldest.data_out, out_payload.data_out, out_payload.data_out);
            errors++;
          end
          if (out_payload.status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, out_payload.status);
            errors++;
          end
          if (out_payload.occupancy !== oldest.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", oldest.occupancy,
                   out_payload.occupancy);
            errors++;
          end
          if (oldest.status == ST_FULL) full_refusals++;
          if (oldest.status == ST_EMPTY) empty_refusals++;
          if (oldest.status == ST_OK && oldest.data_out != 0) words_popped++;
        end
      end
    end
  end

  task automatic add_vector(input logic [REQ_W-1:0] kind, input logic [WORD_W-1:0] word,
                            input bit fixed, input rsp_t rsp);
    request_vector_t v;
    v.req.req_type = kind;
    v.req.data_in  = word;
    v.fixed        = fixed;
    v.rsp          = rsp;
    directed_table.push_back(v);
  endtask

  // hold the request until its transfer, then maybe leave the channel idle
  task automatic send_vector(input request_vector_t v);
    in_valid   <= 1'b1;
    in_payload <= v.req;
    vec_fixed  <= v.fixed;
    vec_rsp    <= v.rsp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_issued++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // random word, with the extremes turning up now and then
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    w = $urandom;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       w = 32'h0000_0000;
        1:       w = 32'hFFFF_FFFF;
        2:       w = 32'h7FFF_FFFF;
        default: w = 32'h8000_0000;
      endcase
    end
    return w;
  endfunction

  initial begin
    request_vector_t v;
    burst_mode_t     mode;
    int unsigned     burst_left;
    bit              do_push;
    int unsigned     phase_idle [4];
    int unsigned     phase_stall [4];

    phase_idle  = '{0, 46, 0, 37};
    phase_stall = '{0, 0, 46, 37};

    // pops on the empty queue after reset, data ignored
    add_vector(REQ_POP_FRONT, 32'h1234_5678, 1'b1, rsp_t'{32'h0, ST_EMPTY, 5'd0});
    add_vector(REQ_POP_BACK,  32'hFFFF_FFFF, 1'b1, rsp_t'{32'h0, ST_EMPTY, 5'd0});
    // extremes in at both ends, out again in the order that shows each end
    add_vector(REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, rsp_t'{32'h0, ST_OK, 5'd1});
    add_vector(REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, rsp_t'{32'h0, ST_OK, 5'd2});
    add_vector(REQ_POP_BACK,   32'h0,         1'b1, rsp_t'{32'h7FFF_FFFF, ST_OK, 5'd1});
    // pop of the last word from the front empties the queue
    add_vector(REQ_POP_FRONT,  32'h0,         1'b1, rsp_t'{32'h8000_0000, ST_OK, 5'd0});
    add_vector(REQ_POP_BACK,   32'h0,         1'b1, rsp_t'{32'h0, ST_EMPTY, 5'd0});
    // fill to capacity from both ends, head wraps around the ring
    for (int i = 0; i < DEPTH; i++) begin
      add_vector((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                 (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : (32'hA5A5_0000 ^ i),
                 1'b0, NO_RSP);
    end
    // full: both pushes refused
    add_vector(REQ_PUSH_FRONT, 32'h0BAD_0001, 1'b1, rsp_t'{32'h0, ST_FULL, 5'd16});
    add_vector(REQ_PUSH_BACK,  32'h0BAD_0002, 1'b1, rsp_t'{32'h0, ST_FULL, 5'd16});
    add_vector(REQ_POP_BACK,   32'h0,         1'b0, NO_RSP);
    add_vector(REQ_POP_FRONT,  32'h0,         1'b0, NO_RSP);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling
    foreach (directed_table[i]) send_vector(directed_table[i]);

    // random part: bursts that fill, drain or mix, so full and empty come often
    burst_left = 0;
    mode       = MODE_MIXED;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = phase_idle[phase];
      stall_pct = phase_stall[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          case ($urandom_range(2))
            0:       mode = MODE_FILL;
            1:       mode = MODE_DRAIN;
            default: mode = MODE_MIXED;
          endcase
          burst_left = $urandom_range(24, 6);
        end
        burst_left--;
        case (mode)
          MODE_FILL:  do_push = ($urandom_range(99) < 85);
          MODE_DRAIN: do_push = ($urandom_range(99) < 15);
          default:    do_push = $urandom_range(1);
        endcase
        if (do_push) begin
          v.req.req_type = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        end else begin
          v.req.req_type = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        end
        v.req.data_in = pick_word();
        v.fixed       = 1'b0;
        v.rsp         = NO_RSP;
        send_vector(v);
      end
    end
    in_valid <= 1'b0;

    // wait for every outstanding result, then watch for strays
    while (!(requests_taken == requests_issued && expected_responses.size() == 0)) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $error("%0d expected results never arrived", expected_responses.size());
      errors++;
    end

    $display("%0d requests over four idling phases, %0d results checked",
             requests_taken, results_seen);
    $display("%0d pushes refused as full, %0d pops refused as empty, %0d nonzero words popped",
             full_refusals, empty_refusals, words_popped);
    if (errors == 0) begin
      $display("bounded_double_ended_queue regression: pass");
    end else begin
      $display("bounded_double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule
